// ----- hdl/ucv_pkg.sv -----
package ucv_pkg;

  localparam logic [15:0] UDP_PROTOCOL = 16'd17;
  // segment halfword that holds the UDP checksum field
  localparam logic [2:0]  CKSUM_INDEX  = 3'd3;
  localparam logic [2:0]  INDEX_SAT    = 3'd4;

  typedef enum logic {
    OP_ADDRESS = 1'b0,
    OP_SEGMENT = 1'b1
  } opcode_t;

  typedef enum logic [1:0] {
    SKIP_NONE     = 2'd0,
    SKIP_FRAGMENT = 2'd1,
    SKIP_ZERO_SUM = 2'd2
  } skip_reason_t;

  typedef struct packed {
    opcode_t     opcode;
    logic [15:0] halfword;
    logic        odd_byte;
    logic        fragmented;
    logic        last;
  } item_t;

  typedef struct packed {
    logic         checksum_bad;
    skip_reason_t skip_reason;
    logic [15:0]  residual;
  } result_t;

endpackage

// ----- hdl/ucv_stream_if.sv -----
interface ucv_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- hdl/udp_checksum_verifier.sv -----
// UDP checksum verifier.
// item (sink): one beat per pseudo-header address halfword or UDP segment
//   halfword, big-endian, packet closed by a beat with last set.
// result (source): one beat per packet, after the packet's last beat.
// Item accepts beats back to back unless the capture stage is full and cannot
// move; back-to-back packets are fine. The running sum is one 32-bit
// end-around add per beat. Closing a packet goes through three registers
// (capture, add of protocol and length, fold) before its result appears.
// When result is stalled the finished results stay in the three-stage
// pipeline; item stays ready until the capture stage is full and cannot
// move, and halfwords of the next packet still flow while earlier results
// wait.
// rst (synchronous) clears the running packet state and empties the
// pipeline; no result is lost or repeated across a stall.
module udp_checksum_verifier (
  input  logic clk,
  input  logic rst,
  ucv_stream_if.sink   item,
  ucv_stream_if.source result
);

  logic [31:0] running_sum;
  logic [15:0] segment_bytes;
  logic [2:0]  segment_index;
  logic        zero_checksum_seen;
  logic        fragment_seen;

  logic [31:0] running_sum_next;
  logic [15:0] segment_bytes_next;
  logic [2:0]  segment_index_next;
  logic        zero_checksum_seen_next;
  logic        fragment_seen_next;
  logic [15:0] data_eff;
  logic [32:0] sum_wide;
  ucv_pkg::skip_reason_t reason_next;

  logic                  p1_v;
  logic [31:0]           p1_sum;
  logic [15:0]           p1_bytes;
  ucv_pkg::skip_reason_t p1_reason;

  logic                  p2_v;
  logic [17:0]           p2_total;
  ucv_pkg::skip_reason_t p2_reason;

  logic             out_v;
  ucv_pkg::result_t out_q;

  logic        out_ready;
  logic        p2_ready;
  logic        p1_ready;
  logic        accept;
  logic [17:0] total;
  logic [16:0] fold1;
  logic [15:0] fold2;

  assign out_ready   = !out_v || result.ready;
  assign p2_ready    = !p2_v || out_ready;
  assign p1_ready    = !p1_v || p2_ready;
  assign item.ready  = p1_ready;
  assign accept      = item.valid && p1_ready;

  always_comb begin
    data_eff                = item.data.halfword;
    segment_bytes_next      = segment_bytes;
    segment_index_next      = segment_index;
    zero_checksum_seen_next = zero_checksum_seen;
    fragment_seen_next      = fragment_seen | item.data.fragmented;
    if (item.data.opcode == ucv_pkg::OP_SEGMENT) begin
      if (item.data.odd_byte) begin
        data_eff           = {item.data.halfword[15:8], 8'h00};
        segment_bytes_next = segment_bytes + 16'd1;
      end else begin
        segment_bytes_next = segment_bytes + 16'd2;
      end
      if (segment_index == ucv_pkg::CKSUM_INDEX && data_eff == 16'h0000) begin
        zero_checksum_seen_next = 1'b1;
      end
      if (segment_index != ucv_pkg::INDEX_SAT) begin
        segment_index_next = segment_index + 3'd1;
      end
    end
    sum_wide         = {1'b0, running_sum} + {17'd0, data_eff};
    running_sum_next = sum_wide[31:0] + {31'd0, sum_wide[32]};
    if (fragment_seen_next) begin
      reason_next = ucv_pkg::SKIP_FRAGMENT;
    end else if (zero_checksum_seen_next) begin
      reason_next = ucv_pkg::SKIP_ZERO_SUM;
    end else begin
      reason_next = ucv_pkg::SKIP_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_sum        <= '0;
      segment_bytes      <= '0;
      segment_index      <= '0;
      zero_checksum_seen <= 1'b0;
      fragment_seen      <= 1'b0;
    end else if (accept) begin
      if (item.data.last) begin
        running_sum        <= '0;
        segment_bytes      <= '0;
        segment_index      <= '0;
        zero_checksum_seen <= 1'b0;
        fragment_seen      <= 1'b0;
      end else begin
        running_sum        <= running_sum_next;
        segment_bytes      <= segment_bytes_next;
        segment_index      <= segment_index_next;
        zero_checksum_seen <= zero_checksum_seen_next;
        fragment_seen      <= fragment_seen_next;
      end
    end
  end

  // capture of a closed packet
  always_ff @(posedge clk) begin
    if (rst) begin
      p1_v <= 1'b0;
    end else if (p1_ready) begin
      p1_v <= accept && item.data.last;
    end
    if (p1_ready && accept) begin
      p1_sum    <= running_sum_next;
      p1_bytes  <= segment_bytes_next;
      p1_reason <= reason_next;
    end
  end

  // sum is never zero after the protocol add, so any congruent value folds right
  assign total = {2'b00, p1_sum[31:16]} + {2'b00, p1_sum[15:0]}
               + {2'b00, p1_bytes} + {2'b00, ucv_pkg::UDP_PROTOCOL};

  always_ff @(posedge clk) begin
    if (rst) begin
      p2_v <= 1'b0;
    end else if (p2_ready) begin
      p2_v <= p1_v;
    end
    if (p2_ready) begin
      p2_total  <= total;
      p2_reason <= p1_reason;
    end
  end

  assign fold1 = {15'd0, p2_total[17:16]} + {1'b0, p2_total[15:0]};
  assign fold2 = fold1[15:0] + {15'd0, fold1[16]};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
    end else if (out_ready) begin
      out_v <= p2_v;
    end
    if (out_ready) begin
      out_q.skip_reason <= p2_reason;
      if (p2_reason == ucv_pkg::SKIP_NONE) begin
        out_q.residual     <= ~fold2;
        out_q.checksum_bad <= (fold2 != 16'hffff);
      end else begin
        out_q.residual     <= '0;
        out_q.checksum_bad <= 1'b0;
      end
    end
  end

  assign result.valid = out_v;
  assign result.data  = out_q;

`ifndef SYNTHESIS
  a_bad_matches_residual: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.data.skip_reason == ucv_pkg::SKIP_NONE
      |-> result.data.checksum_bad == (result.data.residual != 16'h0000))
    else $error("checksum_bad disagrees with residual");

  a_skip_clears_fields: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.data.skip_reason != ucv_pkg::SKIP_NONE
      |-> !result.data.checksum_bad && result.data.residual == 16'h0000)
    else $error("skipped packet carries a residual");

  a_state_cleared: assert property (@(posedge clk) disable iff (rst)
    accept && item.data.last
      |=> running_sum == 32'd0 && segment_bytes == 16'd0 && !fragment_seen)
    else $error("packet state not cleared after last beat");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    !item.ready |-> p1_v && p2_v && out_v && !result.ready)
    else $error("input stalled with room in the pipeline");
`endif

endmodule
